// ----- sv/call_button_latch_cancel_assert.svh -----
// Assertion macros shared by the block's checking code.
`ifndef CALL_BUTTON_LATCH_CANCEL_ASSERT_SVH
`define CALL_BUTTON_LATCH_CANCEL_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CBLC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CBLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cblc_pkg.sv -----
`default_nettype none
package cblc_pkg;
	localparam int MASK_W  = 16;
	localparam int INDEX_W = 5;
	localparam int COUNT_W = 6;
	localparam int SEG_W   = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 6'd60;
	localparam logic [COUNT_W-1:0] LATCH_COUNT  = 6'd10;
	localparam logic [COUNT_W-1:0] RELEASE_STEP = 6'd2;
	localparam logic [COUNT_W-1:0] HOLD_RESET   = 6'd30;

	localparam logic REG_CANCEL_HOLD = 1'b0;

	typedef struct packed {
		logic [MASK_W-1:0]  pressed_mask;
		logic [INDEX_W-1:0] set_index;
		logic [INDEX_W-1:0] clear_index;
		logic [INDEX_W-1:0] blink_index;
		logic               running;
		logic               blink_phase;
		logic [SEG_W-1:0]   segment_code;
		logic [MASK_W-1:0]  lamp_mask;
		logic [MASK_W-1:0]  call_mask;
		logic [MASK_W-1:0]  cancel_mask;
	} cblc_item_t;
endpackage
`default_nettype wire

// ----- sv/cblc_cell.sv -----
`default_nettype none
module cblc_cell #(
	parameter int IDX = 0
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              take,
	input  wire [cblc_pkg::COUNT_W-1:0]      hold,
	input  cblc_pkg::cblc_item_t             item_in,
	output cblc_pkg::cblc_item_t             item_out
);
	logic [cblc_pkg::COUNT_W-1:0] count_q, count_d;
	logic call_q, call_d;
	logic prev_q, prev_d;
	logic armed_q, armed_d;
	logic req_q, req_d;
	logic lamp;
	logic pressed;
	cblc_pkg::cblc_item_t item_d;
	cblc_pkg::cblc_item_t item_q;

	assign pressed = item_in.pressed_mask[IDX];

	always_comb begin
		call_d  = call_q;
		prev_d  = prev_q;
		armed_d = armed_q;
		req_d   = req_q;
		count_d = count_q;
		if (item_in.set_index == cblc_pkg::INDEX_W'(IDX)) begin
			call_d  = 1'b1;
			armed_d = 1'b0;
			req_d   = 1'b0;
		end
		if (item_in.clear_index == cblc_pkg::INDEX_W'(IDX)) begin
			call_d  = 1'b0;
			armed_d = 1'b0;
			req_d   = 1'b0;
		end
		if (!call_d) begin
			armed_d = 1'b0;
			req_d   = 1'b0;
		end
		if (pressed) begin
			if (count_q < cblc_pkg::COUNT_MAX) begin
				count_d = count_q + cblc_pkg::COUNT_W'(1);
			end
			if (!call_d && !prev_q) begin
				if (count_d > cblc_pkg::LATCH_COUNT) begin
					call_d = 1'b1;
					prev_d = 1'b1;
				end
			end else if (!req_d && call_d && armed_d) begin
				if (count_d > hold) begin
					req_d = 1'b1;
				end
			end
		end else begin
			if (count_q > cblc_pkg::COUNT_W'(1)) begin
				count_d = count_q - cblc_pkg::RELEASE_STEP;
			end else begin
				if (call_d) begin
					armed_d = 1'b1;
				end
				prev_d = call_d;
			end
		end
		lamp = call_d;
		if (item_in.blink_index == cblc_pkg::INDEX_W'(IDX) && item_in.running) begin
			lamp = item_in.blink_phase;
		end
		item_d = item_in;
		item_d.lamp_mask[IDX]   = lamp;
		item_d.call_mask[IDX]   = call_d;
		item_d.cancel_mask[IDX] = req_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			call_q  <= 1'b0;
			prev_q  <= 1'b0;
			armed_q <= 1'b0;
			req_q   <= 1'b0;
		end else if (take) begin
			count_q <= count_d;
			call_q  <= call_d;
			prev_q  <= prev_d;
			armed_q <= armed_d;
			req_q   <= req_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item_d;
		end
	end

	assign item_out = item_q;
endmodule
`default_nettype wire

// ----- sv/call_button_latch_cancel.sv -----
// Call button debounce, call latch and long-press cancel.
// Input channel s_*: one item per scan tick carrying the raw pressed states,
// the set, clear and blink button numbers, the run and blink flags and the
// segment pattern. Output channel m_*: one item per input item with the lamp,
// call and cancel masks and the segment lines, in input order.
// The buttons form a row of cells; cell i owns button i and an item walks the
// row one cell per cycle while the cell ahead has space, from the first cell's
// register to the last, and a new item is accepted every cycle unless the row is full.
// The last cell's register is the output register. When the receiver stalls,
// items keep moving until they queue up behind it; s_tready falls only once
// every cell holds an item, and rises again as soon as one moves on.
// The APB port holds cancel_hold_time at address 0; write it only while idle.
// Reset clears all button state and empties the row; cancel_hold_time
// returns to 30.
`default_nettype none
module call_button_latch_cancel #(
	parameter int BUTTONS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// pressed_mask[15:0], set_index[20:16], clear_index[25:21],
	// blink_index[30:26], running[31], blink_phase[32], segment_code[39:33]
	input  wire  [39:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// lamp_mask[15:0], call_mask[31:16], cancel_mask[47:32],
	// segment_lines[54:48], zero[55]
	output logic [55:0] m_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [cblc_pkg::COUNT_W-1:0] hold_q;
	logic [BUTTONS-1:0] v_q;
	logic [BUTTONS-1:0] space;
	logic [BUTTONS-1:0] leave;
	logic [BUTTONS-1:0] take;
	cblc_pkg::cblc_item_t cell_in;
	cblc_pkg::cblc_item_t stage_item [BUTTONS];
	cblc_pkg::cblc_item_t out_item;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= cblc_pkg::HOLD_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == cblc_pkg::REG_CANCEL_HOLD) begin
			hold_q <= pwdata[cblc_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == cblc_pkg::REG_CANCEL_HOLD) begin
			prdata = {26'd0, hold_q};
		end
	end

	always_comb begin
		cell_in              = '0;
		cell_in.pressed_mask = s_tdata[15:0];
		cell_in.set_index    = s_tdata[20:16];
		cell_in.clear_index  = s_tdata[25:21];
		cell_in.blink_index  = s_tdata[30:26];
		cell_in.running      = s_tdata[31];
		cell_in.blink_phase  = s_tdata[32];
		cell_in.segment_code = s_tdata[39:33];
	end

	for (genvar i = 0; i < BUTTONS; i++) begin : g_row
		if (i == BUTTONS - 1) begin : g_last
			assign leave[i] = v_q[i] && m_tready;
		end else begin : g_mid
			assign leave[i] = v_q[i] && space[i+1];
		end
		assign space[i] = !v_q[i] || leave[i];

		if (i == 0) begin : g_first
			assign take[i] = s_tvalid && space[i];
			cblc_cell #(.IDX(i)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.take     (take[i]),
				.hold     (hold_q),
				.item_in  (cell_in),
				.item_out (stage_item[i])
			);
		end else begin : g_next
			assign take[i] = v_q[i-1] && space[i];
			cblc_cell #(.IDX(i)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.take     (take[i]),
				.hold     (hold_q),
				.item_in  (stage_item[i-1]),
				.item_out (stage_item[i])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else begin
				priority if (take[i]) begin
					v_q[i] <= 1'b1;
				end else if (leave[i]) begin
					v_q[i] <= 1'b0;
				end
			end
		end
	end

	assign out_item = stage_item[BUTTONS-1];
	assign s_tready = space[0];
	assign m_tvalid = v_q[BUTTONS-1];
	assign m_tdata  = {1'b0, out_item.segment_code, out_item.cancel_mask,
		out_item.call_mask, out_item.lamp_mask};

`include "call_button_latch_cancel_assert.svh"

	`CBLC_ASSERT_IMPL(a_empty_output_ready, !m_tvalid, s_tready, "row blocked with empty output")
	`CBLC_ASSERT_IMPL(a_cancel_needs_call, m_tvalid, (m_tdata[47:32] & ~m_tdata[31:16]) == 16'd0,
		"cancel request without a latched call")
	`CBLC_ASSERT_IMPL(a_unused_bits_zero, m_tvalid, (m_tdata[31:16] >> BUTTONS) == 16'd0,
		"call bit set beyond the last button")
	`CBLC_ASSERT_NEXT(a_hold_written,
		psel && penable && pwrite && pready && paddr[2] == cblc_pkg::REG_CANCEL_HOLD,
		hold_q == $past(pwdata[cblc_pkg::COUNT_W-1:0]), "cancel hold time not written")
endmodule
`default_nettype wire

// ----- dv/call_button_latch_cancel_test.sv -----
`default_nettype none
module call_button_latch_cancel_test;
	localparam int BUTTONS = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [2:0] HOLD_ADDR = {cblc_pkg::REG_CANCEL_HOLD, 2'b00};

	typedef struct packed {
		logic [cblc_pkg::MASK_W-1:0] lamps;
		logic [cblc_pkg::MASK_W-1:0] calls;
		logic [cblc_pkg::MASK_W-1:0] cancels;
		logic [cblc_pkg::SEG_W-1:0]  segs;
	} lamp_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	// pressed_mask[15:0], set_index[20:16], clear_index[25:21],
	// blink_index[30:26], running[31], blink_phase[32], segment_code[39:33]
	logic [39:0] s_tdata = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	// lamp_mask[15:0], call_mask[31:16], cancel_mask[47:32],
	// segment_lines[54:48], zero[55]
	wire  [55:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	call_button_latch_cancel #(.BUTTONS(BUTTONS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow of the button state inside the block.
	logic [cblc_pkg::COUNT_W-1:0] press_cnt [BUTTONS];
	bit                 call_on [BUTTONS];
	bit                 prev_call [BUTTONS];
	bit                 cancel_armed [BUTTONS];
	bit                 cancel_req [BUTTONS];
	logic [cblc_pkg::COUNT_W-1:0] hold_time = cblc_pkg::HOLD_RESET;

	logic [39:0]  pending_ticks [$];
	lamp_state_t  lamp_states_due [$];
	int           snd_idle_pct = 0;
	int           rcv_stall_pct = 0;
	bit           hold_arm = 1'b0;
	int           hold_left = 0;
	int           mismatches = 0;
	int           cycles = 0;

	// Per-button press and release runs for the random traffic.
	int           run_left [BUTTONS];
	bit           run_pressed [BUTTONS];

	initial begin
		for (int i = 0; i < BUTTONS; i++) begin
			press_cnt[i] = '0;
			call_on[i] = 1'b0;
			prev_call[i] = 1'b0;
			cancel_armed[i] = 1'b0;
			cancel_req[i] = 1'b0;
			run_left[i] = 0;
			run_pressed[i] = 1'b0;
		end
	end

	function automatic lamp_state_t scan_tick(input logic [39:0] d);
		lamp_state_t r;
		logic [cblc_pkg::MASK_W-1:0]  pressed;
		logic [cblc_pkg::INDEX_W-1:0] set_idx;
		logic [cblc_pkg::INDEX_W-1:0] clr_idx;
		logic [cblc_pkg::INDEX_W-1:0] blk_idx;
		logic               run;
		logic               phase;
		bit                 lamp;
		pressed = d[15:0];
		set_idx = d[20:16];
		clr_idx = d[25:21];
		blk_idx = d[30:26];
		run = d[31];
		phase = d[32];
		r = '0;
		r.segs = d[39:33];
		for (int i = 0; i < BUTTONS; i++) begin
			if (set_idx == i) begin
				call_on[i] = 1'b1;
				cancel_req[i] = 1'b0;
				cancel_armed[i] = 1'b0;
			end
			if (clr_idx == i) begin
				call_on[i] = 1'b0;
				cancel_req[i] = 1'b0;
				cancel_armed[i] = 1'b0;
			end
			if (!call_on[i]) begin
				cancel_req[i] = 1'b0;
				cancel_armed[i] = 1'b0;
			end
			if (pressed[i]) begin
				if (press_cnt[i] < cblc_pkg::COUNT_MAX)
					press_cnt[i] = press_cnt[i] + 1'b1;
				if (!call_on[i] && !prev_call[i]) begin
					if (press_cnt[i] > cblc_pkg::LATCH_COUNT) begin
						call_on[i] = 1'b1;
						prev_call[i] = 1'b1;
					end
				end else if (!cancel_req[i] && call_on[i] && cancel_armed[i]) begin
					if (press_cnt[i] > hold_time)
						cancel_req[i] = 1'b1;
				end
			end else if (press_cnt[i] > 1) begin
				press_cnt[i] = press_cnt[i] - cblc_pkg::RELEASE_STEP;
			end else begin
				if (call_on[i])
					cancel_armed[i] = 1'b1;
				prev_call[i] = call_on[i];
			end
			lamp = call_on[i];
			if (blk_idx == i && run)
				lamp = phase;
			r.lamps[i] = lamp;
			r.calls[i] = call_on[i];
			r.cancels[i] = cancel_req[i];
		end
		return r;
	endfunction

	function automatic logic [39:0] make_tick(input logic [15:0] pressed,
			input logic [4:0] set_idx, input logic [4:0] clr_idx,
			input logic [4:0] blk_idx, input logic run, input logic phase,
			input logic [6:0] seg);
		return {seg, phase, run, blk_idx, clr_idx, set_idx, pressed};
	endfunction

	function automatic logic [4:0] pick_button(input int pct);
		if ($urandom_range(99) < pct)
			return 5'($urandom_range(BUTTONS - 1, 0));
		return 5'($urandom_range(31, BUTTONS));
	endfunction

	// Mostly debounced press and release runs per button, with some noise.
	task automatic queue_random_ticks(input int n);
		logic [15:0] pressed;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < BUTTONS; i++) begin
				if (run_left[i] == 0) begin
					run_pressed[i] = !run_pressed[i];
					run_left[i] = run_pressed[i] ? $urandom_range(70, 1) : $urandom_range(35, 1);
				end
				run_left[i]--;
				pressed[i] = run_pressed[i] ^ ($urandom_range(99) < 3);
			end
			if ($urandom_range(99) < 8)
				pressed = 16'($urandom);
			pending_ticks.push_back(make_tick(pressed, pick_button(10), pick_button(8),
				5'($urandom_range(31)), 1'($urandom), 1'($urandom),
				7'($urandom)));
		end
	endtask

	task automatic queue_directed_ticks();
		pending_ticks.push_back(make_tick(16'h0000, 5'd31, 5'd31, 5'd31, 1'b1, 1'b1, 7'h00));
		pending_ticks.push_back(make_tick(16'h0000, 5'd0, 5'd15, 5'd0, 1'b1, 1'b1, 7'h7f));
		pending_ticks.push_back(make_tick(16'h0000, 5'd5, 5'd5, 5'd16, 1'b1, 1'b1, 7'h2a));
		for (int k = 0; k < 11; k++)
			pending_ticks.push_back(make_tick(16'hffff, 5'd16, 5'd16, 5'd2, 1'(k),
				1'(k >> 1), 7'($urandom)));
		for (int k = 0; k < 6; k++)
			pending_ticks.push_back(make_tick(16'h0000, 5'd20, 5'd31, 5'd15, 1'b1,
				1'(k), 7'($urandom)));
		pending_ticks.push_back(make_tick(16'h0000, 5'd3, 5'd4, 5'd3, 1'b0, 1'b1, 7'h55));
	endtask

	task automatic drain();
		while (pending_ticks.size() != 0 || s_tvalid || lamp_states_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_hold_time(input logic [5:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= HOLD_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		hold_time = value;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				lamp_states_due.push_back(scan_tick(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					s_tdata <= pending_ticks.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_arm)
			hold_left <= HOLD_OFF_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h, got %h", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lamp_state_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (lamp_states_due.size() == 0) begin
					report("unexpected item", 16'h0, m_tdata[15:0]);
				end else begin
					want = lamp_states_due.pop_front();
					if (m_tdata[15:0] !== want.lamps)
						report("lamp_mask", want.lamps, m_tdata[15:0]);
					if (m_tdata[31:16] !== want.calls)
						report("call_mask", want.calls, m_tdata[31:16]);
					if (m_tdata[47:32] !== want.cancels)
						report("cancel_mask", want.cancels, m_tdata[47:32]);
					if (m_tdata[54:48] !== want.segs)
						report("segment_lines", 16'(want.segs), 16'(m_tdata[54:48]));
					if (m_tdata[55] !== 1'b0)
						report("padding", 16'h0, 16'(m_tdata[55]));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed_ticks();
		queue_random_ticks(120);
		drain();

		write_hold_time(6'd0);
		snd_idle_pct <= 80;
		queue_random_ticks(140);
		drain();

		// The receiver holds off for a long stretch while items keep coming.
		write_hold_time(cblc_pkg::COUNT_MAX);
		snd_idle_pct <= 0;
		rcv_stall_pct <= 80;
		queue_random_ticks(140);
		hold_arm <= 1'b1;
		@(posedge clk);
		hold_arm <= 1'b0;
		drain();

		write_hold_time(6'($urandom_range(59, 1)));
		snd_idle_pct <= 8;
		rcv_stall_pct <= 8;
		queue_random_ticks(150);
		drain();

		write_hold_time(6'($urandom_range(20, 5)));
		snd_idle_pct <= 0;
		rcv_stall_pct <= 0;
		queue_random_ticks(150);
		drain();

		repeat (3 * BUTTONS) @(posedge clk);
		if (lamp_states_due.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
